[rtl/core/ssrs_pkg.sv]
package ssrs_pkg;

   localparam int CounterWidth = 8;
   localparam int LimitWidth   = 8;
   localparam int CompareWidth = (CounterWidth > LimitWidth) ? CounterWidth : LimitWidth;

   typedef logic [CounterWidth-1:0] count_type;
   typedef logic [LimitWidth-1:0]   limit_type;

   typedef enum logic [2:0] {
      STEP_INIT    = 3'd0,
      STEP_RESET   = 3'd1,
      STEP_CHECK   = 3'd2,
      STEP_PREPARE = 3'd3,
      STEP_READY   = 3'd4,
      STEP_SEND    = 3'd5,
      STEP_OFF     = 3'd6
   } step_type;

   typedef enum logic [1:0] {
      EXIT_OK      = 2'd0,
      EXIT_NO_NET  = 2'd1,
      EXIT_NO_PREP = 2'd2,
      EXIT_NO_SEND = 2'd3
   } exit_type;

   typedef enum logic [1:0] {
      BUILD_NONE    = 2'd0,
      BUILD_SAMPLES = 2'd1,
      BUILD_ALERT   = 2'd2
   } build_type;

   typedef enum logic [2:0] {
      REG_CHECK_LIMIT   = 3'd0,
      REG_PREPARE_LIMIT = 3'd1,
      REG_READY_LIMIT   = 3'd2,
      REG_SEND_LIMIT    = 3'd3,
      REG_FULL_LIMIT    = 3'd4,
      REG_PARTIAL_LIMIT = 3'd5
   } reg_index_type;

   localparam limit_type RetryLimitReset  = LimitWidth'(3);
   localparam limit_type RebootLimitReset = LimitWidth'(2);

   function automatic count_type bump(input count_type c);
      return c + count_type'(1);
   endfunction

   function automatic logic hit(input count_type c, input limit_type l);
      return CompareWidth'(c) == CompareWidth'(l);
   endfunction

   function automatic logic at_least(input count_type c, input limit_type l);
      return CompareWidth'(c) >= CompareWidth'(l);
   endfunction

endpackage

[rtl/core/sms_send_retry_sequencer.sv]
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the input stalls while a result waits, and
// a new item is accepted in the same cycle that the waiting result is taken.
// Reset (synchronous, active high) returns the sequencer to the init step,
// clears all failure and reboot counters and loads the default limits.
module sms_send_retry_sequencer import ssrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_outcome_ok,
   input  logic [1:0]  req_message_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_next_action,
   output logic [1:0]  rsp_build_kind,
   output logic        rsp_finished,
   output logic [1:0]  rsp_exit_code,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   limit_type check_limit_ff, prepare_limit_ff, ready_limit_ff, send_limit_ff;
   limit_type full_limit_ff, partial_limit_ff;

   step_type  step_ff, step_in;
   count_type net_fail_ff, net_fail_in, prep_fail_ff, prep_fail_in;
   count_type ready_fail_ff, ready_fail_in, send_fail_ff, send_fail_in;
   count_type full_done_ff, full_done_in, partial_done_ff, partial_done_in;
   exit_type  pending_ff, pending_in;

   logic      rsp_valid_ff;
   step_type  action_ff;
   build_type build_ff, build_in;
   logic      finished_ff, finished_in;
   exit_type  code_ff, code_in;

   logic      accept;
   count_type bumped;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_action = action_ff;
   assign rsp_build_kind  = build_ff;
   assign rsp_finished    = finished_ff;
   assign rsp_exit_code   = code_ff;

   always_comb begin
      step_in         = step_ff;
      net_fail_in     = net_fail_ff;
      prep_fail_in    = prep_fail_ff;
      ready_fail_in   = ready_fail_ff;
      send_fail_in    = send_fail_ff;
      full_done_in    = full_done_ff;
      partial_done_in = partial_done_ff;
      pending_in      = pending_ff;
      build_in        = BUILD_NONE;
      finished_in     = 1'b0;
      code_in         = EXIT_OK;
      bumped          = '0;
      unique case (step_ff)
         STEP_RESET: begin
            step_in = STEP_CHECK;
         end
         STEP_CHECK: begin
            if (req_outcome_ok) begin
               net_fail_in = '0;
               step_in     = STEP_PREPARE;
            end else begin
               bumped      = bump(net_fail_ff);
               net_fail_in = bumped;
               if (hit(bumped, check_limit_ff)) begin
                  net_fail_in = '0;
                  if (at_least(full_done_ff, full_limit_ff)) begin
                     pending_in = EXIT_NO_NET;
                     step_in    = STEP_OFF;
                  end else begin
                     full_done_in = bump(full_done_ff);
                     step_in      = STEP_RESET;
                  end
               end
            end
         end
         STEP_PREPARE: begin
            if (req_outcome_ok) begin
               prep_fail_in = '0;
               step_in      = STEP_READY;
            end else begin
               bumped       = bump(prep_fail_ff);
               prep_fail_in = bumped;
               if (hit(bumped, prepare_limit_ff)) begin
                  prep_fail_in = '0;
                  if (at_least(full_done_ff, partial_limit_ff)) begin
                     pending_in = EXIT_NO_PREP;
                     step_in    = STEP_OFF;
                  end else begin
                     step_in = STEP_CHECK;
                  end
               end
            end
         end
         STEP_READY: begin
            if (req_outcome_ok) begin
               ready_fail_in = '0;
               build_in      = (req_message_kind == 2'd0) ? BUILD_SAMPLES : BUILD_ALERT;
               step_in       = STEP_SEND;
            end else begin
               bumped        = bump(ready_fail_ff);
               ready_fail_in = bumped;
               if (hit(bumped, ready_limit_ff)) begin
                  ready_fail_in = '0;
                  if (at_least(partial_done_ff, partial_limit_ff)) begin
                     pending_in = EXIT_NO_SEND;
                     step_in    = STEP_OFF;
                  end else begin
                     partial_done_in = bump(partial_done_ff);
                     step_in         = STEP_CHECK;
                  end
               end
            end
         end
         STEP_SEND: begin
            if (req_outcome_ok) begin
               send_fail_in = '0;
               pending_in   = EXIT_OK;
               step_in      = STEP_OFF;
            end else begin
               bumped       = bump(send_fail_ff);
               send_fail_in = bumped;
               if (hit(bumped, send_limit_ff)) begin
                  send_fail_in = '0;
                  if (at_least(partial_done_ff, partial_limit_ff)) begin
                     pending_in = EXIT_NO_SEND;
                     step_in    = STEP_OFF;
                  end else begin
                     partial_done_in = bump(partial_done_ff);
                     step_in         = STEP_READY;
                  end
               end
            end
         end
         STEP_OFF: begin
            finished_in     = 1'b1;
            code_in         = pending_ff;
            net_fail_in     = '0;
            prep_fail_in    = '0;
            ready_fail_in   = '0;
            send_fail_in    = '0;
            full_done_in    = '0;
            partial_done_in = '0;
            pending_in      = EXIT_OK;
            step_in         = STEP_INIT;
         end
         default: begin
            step_in = STEP_CHECK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_limit_ff   <= RetryLimitReset;
         prepare_limit_ff <= RetryLimitReset;
         ready_limit_ff   <= RetryLimitReset;
         send_limit_ff    <= RetryLimitReset;
         full_limit_ff    <= RebootLimitReset;
         partial_limit_ff <= RebootLimitReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CHECK_LIMIT:   check_limit_ff   <= csr_data;
            REG_PREPARE_LIMIT: prepare_limit_ff <= csr_data;
            REG_READY_LIMIT:   ready_limit_ff   <= csr_data;
            REG_SEND_LIMIT:    send_limit_ff    <= csr_data;
            REG_FULL_LIMIT:    full_limit_ff    <= csr_data;
            REG_PARTIAL_LIMIT: partial_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= STEP_INIT;
         net_fail_ff     <= '0;
         prep_fail_ff    <= '0;
         ready_fail_ff   <= '0;
         send_fail_ff    <= '0;
         full_done_ff    <= '0;
         partial_done_ff <= '0;
         pending_ff      <= EXIT_OK;
      end else if (accept) begin
         step_ff         <= step_in;
         net_fail_ff     <= net_fail_in;
         prep_fail_ff    <= prep_fail_in;
         ready_fail_ff   <= ready_fail_in;
         send_fail_ff    <= send_fail_in;
         full_done_ff    <= full_done_in;
         partial_done_ff <= partial_done_in;
         pending_ff      <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= step_in;
         build_ff    <= build_in;
         finished_ff <= finished_in;
         code_ff     <= code_in;
      end
   end

   // A finished item always restarts the sequence from init.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_next_action == STEP_INIT)
      else $error("finished item without a restart at init");

   // A build request only comes with the send that follows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_build_kind != BUILD_NONE |-> rsp_next_action == STEP_SEND)
      else $error("build request without a send");

   // The exit code is zero unless the item reports completion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_finished |-> rsp_exit_code == EXIT_OK)
      else $error("exit code on an unfinished item");

   // The last action issued is the step whose outcome the next item reports.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_action == step_ff)
      else $error("issued action and current step disagree");

   // Counters are clear once a turn off has completed.
   assert property (@(posedge clock) disable iff (reset)
      accept && step_ff == STEP_OFF |=> full_done_ff == '0 && partial_done_ff == '0)
      else $error("reboot counters survived a turn off");

endmodule
